### hw/rtl/wfs_pkg.sv
// Package: shared types, constants and the CORDIC angle table for the waypoint follower.
`default_nettype none
package wfs_pkg;

   localparam int MaxPoints   = 64;
   localparam int SlotW       = $clog2(MaxPoints);
   localparam int CountW      = SlotW + 1;
   localparam int CordicSteps = 16;
   localparam int StepW       = $clog2(CordicSteps + 1);
   localparam int CoordW      = 20;
   localparam int DiffW       = CoordW + 1;
   localparam int CordW       = DiffW + 3;
   localparam int SqW         = 2 * DiffW;
   localparam int DistW       = SqW + 1;

   localparam logic [1:0] OP_WRITE    = 2'd0;
   localparam logic [1:0] OP_LOCALIZE = 2'd1;
   localparam logic [1:0] OP_DRIVE    = 2'd2;

   localparam logic [2:0] REG_POINT_COUNT = 3'd0;
   localparam logic [2:0] REG_REACH       = 3'd1;
   localparam logic [2:0] REG_DEAD        = 3'd2;
   localparam logic [2:0] REG_DRIFT_ANGLE = 3'd3;
   localparam logic [2:0] REG_DRIFT_SPEED = 3'd4;
   localparam logic [2:0] REG_BRAKE_ANGLE = 3'd5;
   localparam logic [2:0] REG_BRAKE_SPEED = 3'd6;

   localparam logic [11:0] SlowSpeed   = 12'd64;
   localparam logic [6:0]  SlowLimit   = 7'd125;
   localparam logic [5:0]  ReverseLoad = 6'd60;
   localparam logic [2:0]  ReachGuard  = 3'd4;

   typedef struct packed {
      logic [1:0]         op;
      logic [5:0]         point_index;
      logic signed [19:0] pos_x;
      logic signed [19:0] pos_y;
      logic [15:0]        heading;
      logic [11:0]        speed;
   } req_type;

   typedef struct packed {
      logic               accelerate;
      logic               brake_key;
      logic               steer_left;
      logic               steer_right;
      logic               drift_hold;
      logic [5:0]         target_slot;
      logic signed [15:0] heading_error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_L_READ, ST_L_DIFF, ST_L_SQ, ST_L_CORDIC, ST_L_EVAL,
      ST_D_MOD, ST_D_READ, ST_D_DIFF, ST_D_SQ, ST_D_EVAL, ST_D_CORDIC, ST_D_KEYS, ST_OUT
   } state_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      begin
         unique case (i)
            5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            default: r = 32'h0;
         endcase
         return r;
      end
   endfunction

endpackage
`default_nettype wire

### hw/rtl/waypoint_follow_steering_top.sv
// Top level: waypoint follower with bang-bang steering, sequencer and register file.
// Ops 0 and 3 answer straight from the output state; op 1 scans every waypoint,
// running a CORDIC for each one not on the pose, and scans them all once more,
// without CORDIC, when none lies ahead; op 2 wraps a stale pointer, then makes
// one to five waypoint reads and one CORDIC.
// One item in flight; reset is synchronous and leaves the waypoint memory as is.
`default_nettype none
module waypoint_follow_steering_top
   import wfs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   // configuration registers
   logic [6:0]  count_ff;
   logic [15:0] reach_ff;
   logic [14:0] dead_ff, drift_ang_ff, brake_ang_ff;
   logic [11:0] drift_spd_ff, brake_spd_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; reach_ff <= 16'd352; dead_ff <= 15'd546;
         drift_ang_ff <= 15'd4369; drift_spd_ff <= 12'd880;
         brake_ang_ff <= 15'd11833; brake_spd_ff <= 12'd960;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_POINT_COUNT: count_ff     <= csr_data[6:0];
            REG_REACH:       reach_ff     <= csr_data[15:0];
            REG_DEAD:        dead_ff      <= csr_data[14:0];
            REG_DRIFT_ANGLE: drift_ang_ff <= csr_data[14:0];
            REG_DRIFT_SPEED: drift_spd_ff <= csr_data[11:0];
            REG_BRAKE_ANGLE: brake_ang_ff <= csr_data[14:0];
            REG_BRAKE_SPEED: brake_spd_ff <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   // active count, saturated
   logic [CountW-1:0] n_act;
   assign n_act = (count_ff > 7'(MaxPoints)) ? CountW'(MaxPoints) : CountW'(count_ff);

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [SlotW-1:0] ptr_ff, ptr_in;
   logic [6:0]  slow_ff, slow_in;
   logic [5:0]  rev_ff, rev_in;
   logic [SlotW-1:0] idx_ff, idx_in, best_ff, best_in;
   logic [CountW-1:0] scan_ff, scan_in;
   logic        pass2_ff, pass2_in, found_ff, found_in;
   logic [DistW-1:0] best_d_ff, best_d_in;
   logic [2:0]  guard_ff, guard_in;
   logic signed [DiffW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [DistW-1:0] d_ff, d_in;
   logic [31:0] r2_ff, r2_in;

   // waypoint memory
   logic                 wr_en;
   logic [2*CoordW-1:0]  rd_data;
   logic [SlotW-1:0]     rd_addr;
   wfs_point_ram u_ram (
      .clock, .wr_en, .wr_addr(req_ff.point_index[SlotW-1:0]),
      .wr_data({req_ff.pos_x, req_ff.pos_y}), .rd_addr, .rd_data);

   // CORDIC
   logic        c_start, c_done;
   logic [15:0] c_angle;
   wfs_cordic u_cordic (
      .clock, .reset, .start(c_start), .vec_y(dy_ff), .vec_x(-dx_ff),
      .done(c_done), .angle(c_angle));

   logic signed [15:0] err;
   logic [16:0] mag;
   logic [SlotW-1:0] ptr_next;
   logic [6:0] slow_t;
   logic [5:0] rev_t;
   logic signed [CoordW-1:0] wx, wy;

   assign err  = $signed(c_angle - req_ff.heading);
   assign mag  = err[15] ? 17'(-$signed({err[15], err})) : 17'(err);
   assign wx   = rd_data[2*CoordW-1:CoordW];
   assign wy   = rd_data[CoordW-1:0];
   assign ptr_next = (CountW'(idx_ff) + 1'b1 == n_act) ? '0 : idx_ff + 1'b1;
   assign rd_addr  = idx_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // found decision at end of first pass uses the updated flag
   logic l_hit;
   always_comb begin
      l_hit = 1'b0;
      if (state_ff == ST_L_EVAL) begin
         if (pass2_ff) l_hit = 1'b1;
         else l_hit = !(dx_ff == '0 && dy_ff == '0)
                      && (err > -16'sd16384) && (err < 16'sd16384);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            priority if (req_data.op == OP_LOCALIZE && n_act != '0) state_in = ST_L_READ;
            else if (req_data.op == OP_DRIVE && n_act != '0) state_in = ST_D_MOD;
            else state_in = ST_OUT;
         end
         ST_L_READ:   state_in = ST_L_DIFF;
         ST_L_DIFF:   state_in = ST_L_SQ;
         ST_L_SQ:     state_in = (pass2_ff || (dx_ff == '0 && dy_ff == '0)) ? ST_L_EVAL
                                 : ST_L_CORDIC;
         ST_L_CORDIC: if (c_done) state_in = ST_L_EVAL;
         ST_L_EVAL: begin
            if (scan_ff + 1'b1 == n_act) begin
               state_in = (!pass2_ff && !(found_ff || l_hit)) ? ST_L_READ : ST_OUT;
            end else state_in = ST_L_READ;
         end
         // wrap a stale pointer into the active count, one subtraction a cycle
         ST_D_MOD:    state_in = (CountW'(idx_ff) >= n_act) ? ST_D_MOD : ST_D_READ;
         ST_D_READ:   state_in = ST_D_DIFF;
         ST_D_DIFF:   state_in = ST_D_SQ;
         ST_D_SQ:     state_in = ST_D_EVAL;
         ST_D_EVAL:   state_in = (guard_ff != ReachGuard && d_ff <= DistW'(r2_ff))
                                 ? ST_D_READ : ST_D_CORDIC;
         ST_D_CORDIC: if (c_done) state_in = ST_D_KEYS;
         ST_D_KEYS:   state_in = ST_OUT;
         ST_OUT:      if (rsp_valid_ff && rsp_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in = req_ff; rsp_in = rsp_ff; rsp_valid_in = rsp_valid_ff;
      ptr_in = ptr_ff; slow_in = slow_ff; rev_in = rev_ff;
      idx_in = idx_ff; best_in = best_ff; scan_in = scan_ff;
      pass2_in = pass2_ff; found_in = found_ff; best_d_in = best_d_ff;
      guard_in = guard_ff; dx_in = dx_ff; dy_in = dy_ff; d_in = d_ff; r2_in = r2_ff;
      wr_en = 1'b0; c_start = 1'b0; slow_t = slow_ff; rev_t = rev_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            req_in = req_data;
            idx_in = '0; scan_in = '0; pass2_in = 1'b0; found_in = 1'b0;
            guard_in = '0;
            r2_in = 32'(reach_ff) * 32'(reach_ff);
            if (req_data.op == OP_DRIVE) idx_in = ptr_ff;
         end
         ST_D_MOD: begin
            if (CountW'(idx_ff) >= n_act) idx_in = SlotW'(CountW'(idx_ff) - n_act);
         end
         ST_L_DIFF, ST_D_DIFF: begin
            dx_in = DiffW'(wx) - DiffW'(req_ff.pos_x);
            dy_in = DiffW'(wy) - DiffW'(req_ff.pos_y);
         end
         ST_L_SQ, ST_D_SQ: begin
            d_in = DistW'(SqW'(dx_ff * dx_ff)) + DistW'(SqW'(dy_ff * dy_ff));
            if (state_ff == ST_L_SQ && !pass2_ff && !(dx_ff == '0 && dy_ff == '0))
               c_start = 1'b1;
         end
         ST_L_EVAL: begin
            if (l_hit && (!found_in || d_ff < best_d_ff)) begin
               found_in = 1'b1; best_d_in = d_ff; best_in = idx_ff;
            end
            if (scan_ff + 1'b1 == n_act) begin
               scan_in = '0; idx_in = '0;
               if (!pass2_ff && !found_in) pass2_in = 1'b1;
               else begin
                  ptr_in = found_in ? best_in : '0;
                  rsp_in = '0; rsp_in.target_slot = 6'(found_in ? best_in : '0);
                  rsp_valid_in = 1'b1;
               end
            end else begin
               scan_in = scan_ff + 1'b1; idx_in = idx_ff + 1'b1;
            end
         end
         ST_D_EVAL: begin
            if (guard_ff != ReachGuard && d_ff <= DistW'(r2_ff)) begin
               guard_in = guard_ff + 1'b1; idx_in = ptr_next;
            end else c_start = 1'b1;
         end
         ST_D_KEYS: begin
            ptr_in = idx_ff;
            slow_t = (req_ff.speed < SlowSpeed) ? slow_ff + 1'b1 : '0;
            if (slow_t > SlowLimit) begin slow_t = '0; rev_t = ReverseLoad; end
            rsp_in = '0; rsp_in.target_slot = 6'(idx_ff); rsp_in.heading_error = err;
            if (rev_t != '0) begin
               rev_t = rev_t - 1'b1;
               rsp_in.brake_key = 1'b1;
               if (err > $signed({1'b0, dead_ff})) rsp_in.steer_left = 1'b1;
               else if (err < -$signed({1'b0, dead_ff})) rsp_in.steer_right = 1'b1;
            end else begin
               rsp_in.accelerate = 1'b1;
               if (err > $signed({1'b0, dead_ff})) rsp_in.steer_right = 1'b1;
               else if (err < -$signed({1'b0, dead_ff})) rsp_in.steer_left = 1'b1;
               if (mag > 17'(brake_ang_ff) && req_ff.speed > brake_spd_ff) begin
                  rsp_in.accelerate = 1'b0; rsp_in.brake_key = 1'b1;
               end
               if (mag > 17'(drift_ang_ff) && req_ff.speed > drift_spd_ff)
                  rsp_in.drift_hold = 1'b1;
            end
            slow_in = slow_t; rev_in = rev_t; rsp_valid_in = 1'b1;
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               // ops that answer at once
               rsp_in = '0; rsp_valid_in = 1'b1;
               if (req_ff.op == OP_WRITE) begin
                  wr_en = (32'(req_ff.point_index) < 32'(MaxPoints));
                  ptr_in = '0; slow_in = '0; rev_in = '0;
                  rsp_in.target_slot = '0;
               end else rsp_in.target_slot = 6'(ptr_ff);
            end else if (rsp_ready) rsp_valid_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in; rsp_ff <= rsp_in;
      idx_ff <= idx_in; best_ff <= best_in; best_d_ff <= best_d_in;
      dx_ff <= dx_in; dy_ff <= dy_in; d_ff <= d_in; r2_ff <= r2_in;
      scan_ff <= scan_in; pass2_ff <= pass2_in; found_ff <= found_in; guard_ff <= guard_in;
      if (reset) begin
         state_ff <= ST_IDLE; rsp_valid_ff <= 1'b0;
         ptr_ff <= '0; slow_ff <= '0; rev_ff <= '0;
      end else begin
         state_ff <= state_in; rsp_valid_ff <= rsp_valid_in;
         ptr_ff <= ptr_in; slow_ff <= slow_in; rev_ff <= rev_in;
      end
   end
endmodule
`default_nettype wire

### hw/rtl/wfs_cordic.sv
// Iterative CORDIC vectoring unit: bearing of (y, x) in 16-bit binary angle units.
`default_nettype none
module wfs_cordic
   import wfs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [DiffW-1:0]  vec_y,
   input  wire logic signed [DiffW-1:0]  vec_x,
   output logic                          done,
   output logic [15:0]                   angle
);
   logic signed [CordW-1:0] x_ff, x_in, y_ff, y_in;
   logic [31:0]             z_ff, z_in;
   logic [StepW-1:0]        step_ff, step_in;
   logic                    busy_ff, busy_in, zero_ff, zero_in;
   logic signed [CordW-1:0] xs, ys;
   logic [31:0]             zr;

   assign xs = x_ff >>> step_ff;
   assign ys = y_ff >>> step_ff;
   assign zr = z_ff + 32'h8000;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      step_in = step_ff; busy_in = busy_ff; zero_in = zero_ff;
      done = 1'b0;
      if (start) begin
         // fold the left half plane onto the right
         zero_in = (vec_x == '0) && (vec_y == '0);
         if (vec_x < 0) begin
            x_in = -CordW'(vec_x); y_in = -CordW'(vec_y); z_in = 32'h80000000;
         end else begin
            x_in = CordW'(vec_x); y_in = CordW'(vec_y); z_in = '0;
         end
         step_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff == StepW'(CordicSteps)) begin
            busy_in = 1'b0; done = 1'b1;
         end else begin
            if (y_ff >= 0) begin
               x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + atan_entry(5'(step_ff));
            end else begin
               x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - atan_entry(5'(step_ff));
            end
            step_in = step_ff + 1'b1;
         end
      end
   end

   assign angle = zero_ff ? 16'd0 : zr[31:16];

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; step_ff <= step_in; zero_ff <= zero_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end
endmodule
`default_nettype wire

### hw/rtl/wfs_point_ram.sv
// Waypoint memory: one write port, one registered read port.
`default_nettype none
module wfs_point_ram
   import wfs_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [SlotW-1:0]          wr_addr,
   input  wire logic [2*CoordW-1:0]       wr_data,
   input  wire logic [SlotW-1:0]          rd_addr,
   output logic      [2*CoordW-1:0]       rd_data
);
   logic [2*CoordW-1:0] mem [MaxPoints];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
